// File: sv/button_debounce_long_press_assert.svh
// Assertion helpers shared by the button debounce RTL.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BDLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition on one edge is followed by another on the next edge.
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bdlp_pkg.sv
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int NUM_BUTTONS  = 7;
  localparam int TIME_BITS    = 16;
  localparam int FIELD_COUNT  = 7;
  localparam int CENTER_POS   = 4;
  localparam int CFG_BITS     = 16;
  localparam int CFG_ADDR_BITS = 2;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(50);
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(1000);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1
  } cfg_reg_e;

  // Accepted level change of one button in the current tick.
  typedef struct packed {
    logic press;
    logic release_seen;
  } evt_t;

  // Saturating increment of a time counter.
  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    return (&v) ? v : v + TIME_BITS'(1);
  endfunction

  // Unsigned compare a > b across a time counter and a threshold register.
  function automatic logic time_gt(input logic [TIME_BITS-1:0] a,
                                   input logic [CFG_BITS-1:0] b);
    return 33'(a) > 33'(b);
  endfunction

endpackage

// File: sv/button_debounce_long_press.sv
`timescale 1ns / 1ps
// A result item is registered and presented in the cycle after its tick item is accepted.
// Throughput: one item per cycle while out_ready_i is high; the output register frees as it is taken,
// so a new item is accepted in the same cycle that the previous result leaves.
// Reset (rst_ni low, asynchronous): buttons read as released, all counters clear,
// thresholds return to 50 and 1000 ticks, and no result is pending.

`include "button_debounce_long_press_assert.svh"

module button_debounce_long_press (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [bdlp_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [bdlp_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  // tick item
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               level_up_i,
  input  logic                               level_down_i,
  input  logic                               level_left_i,
  input  logic                               level_right_i,
  input  logic                               level_center_i,
  input  logic                               level_vol_up_i,
  input  logic                               level_vol_down_i,
  // result item
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               press_up_o,
  output logic                               press_down_o,
  output logic                               press_left_o,
  output logic                               press_right_o,
  output logic                               press_vol_up_o,
  output logic                               press_vol_down_o,
  output logic                               center_short_press_o,
  output logic                               center_long_held_o
);

  localparam int OUT_COUNT = 8;

  // Slots of the result vector.
  localparam int SLOT_UP    = 0;
  localparam int SLOT_DOWN  = 1;
  localparam int SLOT_LEFT  = 2;
  localparam int SLOT_RIGHT = 3;
  localparam int SLOT_VUP   = 4;
  localparam int SLOT_VDOWN = 5;
  localparam int SLOT_SHORT = 6;
  localparam int SLOT_LONG  = 7;

  // Threshold registers.
  logic [bdlp_pkg::CFG_BITS-1:0] debounce_q;
  logic [bdlp_pkg::CFG_BITS-1:0] long_press_q;

  // Centre press timing.
  logic [bdlp_pkg::TIME_BITS-1:0] held_q;
  logic [bdlp_pkg::TIME_BITS-1:0] held_d;
  logic [bdlp_pkg::TIME_BITS-1:0] held_inc;
  logic                           center_held_q;
  logic                           center_held_d;

  // Output register.
  logic                 out_valid_q;
  logic [OUT_COUNT-1:0] result_q;
  logic [OUT_COUNT-1:0] result_d;

  logic                                   tick;
  logic [bdlp_pkg::FIELD_COUNT-1:0]       level;
  bdlp_pkg::evt_t [bdlp_pkg::FIELD_COUNT-1:0] evt;

  // Accept a tick whenever the output register is empty or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign tick       = in_valid_i && in_ready_o;

  assign level = {level_vol_down_i, level_vol_up_i, level_center_i, level_right_i,
                  level_left_i, level_down_i, level_up_i};

  // One debounce cell per fitted button; absent buttons never report a change.
  for (genvar b = 0; b < bdlp_pkg::FIELD_COUNT; b++) begin : g_btn
    if (b < bdlp_pkg::NUM_BUTTONS) begin : g_cell
      bdlp_debounce u_debounce (
        .clk_i            (clk_i),
        .rst_ni           (rst_ni),
        .tick_i           (tick),
        .level_i          (level[b]),
        .debounce_ticks_i (debounce_q),
        .evt_o            (evt[b])
      );
    end else begin : g_absent
      assign evt[b] = '0;
    end
  end

  // Held time counts every tick; an accepted centre press restarts it.
  // The short-press decision sees the count after this tick's increment.
  assign held_inc = bdlp_pkg::sat_inc(held_q);

  always_comb begin
    held_d        = held_inc;
    center_held_d = center_held_q;
    if (evt[bdlp_pkg::CENTER_POS].press) begin
      held_d        = '0;
      center_held_d = 1'b1;
    end else if (evt[bdlp_pkg::CENTER_POS].release_seen) begin
      center_held_d = 1'b0;
    end
  end

  always_comb begin
    result_d             = '0;
    result_d[SLOT_UP]    = evt[0].press;
    result_d[SLOT_DOWN]  = evt[1].press;
    result_d[SLOT_LEFT]  = evt[2].press;
    result_d[SLOT_RIGHT] = evt[3].press;
    result_d[SLOT_VUP]   = evt[5].press;
    result_d[SLOT_VDOWN] = evt[6].press;
    result_d[SLOT_SHORT] = evt[bdlp_pkg::CENTER_POS].release_seen &&
                           !bdlp_pkg::time_gt(held_inc, long_press_q) &&
                           (33'(held_inc) != 33'(long_press_q));
    // Long-held status comes from the state as it stands after this tick.
    result_d[SLOT_LONG]  = center_held_d &&
                           !bdlp_pkg::time_gt(long_press_q, held_d);
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bdlp_pkg::DEBOUNCE_RESET;
      long_press_q <= bdlp_pkg::LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bdlp_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        bdlp_pkg::REG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Advance centre timing on each accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= '0;
      center_held_q <= 1'b0;
    end else if (tick) begin
      held_q        <= held_d;
      center_held_q <= center_held_d;
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign press_up_o           = result_q[SLOT_UP];
  assign press_down_o         = result_q[SLOT_DOWN];
  assign press_left_o         = result_q[SLOT_LEFT];
  assign press_right_o        = result_q[SLOT_RIGHT];
  assign press_vol_up_o       = result_q[SLOT_VUP];
  assign press_vol_down_o     = result_q[SLOT_VDOWN];
  assign center_short_press_o = result_q[SLOT_SHORT];
  assign center_long_held_o   = result_q[SLOT_LONG];

  // A short press ends the hold, so it never coincides with the long status.
  `BDLP_ASSERT(a_short_long_excl, !(out_valid_q && result_q[SLOT_SHORT] && result_q[SLOT_LONG]), "short press and long hold together")
  // An empty output register always takes a tick.
  `BDLP_ASSERT(a_ready_when_empty, out_valid_q || in_ready_o, "ready low with empty output")
  // Every accepted tick leaves a result pending.
  `BDLP_ASSERT_NEXT(a_tick_gives_result, tick, out_valid_q, "accepted tick lost its result")
  // A long hold is only reported while the centre is held.
  `BDLP_ASSERT(a_long_needs_hold, !(out_valid_q && result_q[SLOT_LONG]) || center_held_q, "long hold without centre held")

endmodule

// File: sv/bdlp_debounce.sv
`timescale 1ns / 1ps

module bdlp_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          level_i,
  input  logic [bdlp_pkg::CFG_BITS-1:0] debounce_ticks_i,
  output bdlp_pkg::evt_t                evt_o
);

  logic                           raw_prev_q;
  logic                           stable_q;
  logic [bdlp_pkg::TIME_BITS-1:0] quiet_q;
  logic [bdlp_pkg::TIME_BITS-1:0] quiet_d;
  logic                           settled;

  // restart quiet time on any raw change, else count up and saturate
  assign quiet_d = (level_i != raw_prev_q) ? '0 : bdlp_pkg::sat_inc(quiet_q);
  assign settled = bdlp_pkg::time_gt(quiet_d, debounce_ticks_i);

  assign evt_o.press        = settled && !level_i && stable_q;
  assign evt_o.release_seen = settled && level_i && !stable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q <= 1'b1;
      stable_q   <= 1'b1;
      quiet_q    <= '0;
    end else if (tick_i) begin
      raw_prev_q <= level_i;
      quiet_q    <= quiet_d;
      if (settled) begin
        stable_q <= level_i;
      end
    end
  end

endmodule
